>>> rtl/dps_pkg.sv
// Package for the dijet pair selector: payload structs, status codes,
// register indexes, size constants and the azimuth wrap helper. No dependencies.
`default_nettype none
package dps_pkg;

	localparam int DPS_MAX_JETS = 64;

	localparam int PT_W    = 16;
	localparam int ETA_W   = 12;
	localparam int PHI_W   = 12;
	localparam int ASYM_W  = 16;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_JET_PT    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEAD_PT   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ABS_ETA   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELTA_PHI = 4'd3;

	localparam logic [PT_W-1:0]  RST_MIN_JET_PT    = 16'd128;
	localparam logic [PT_W-1:0]  RST_MIN_LEAD_PT   = 16'd320;
	localparam logic [ETA_W-1:0] RST_MAX_ABS_ETA   = 12'd358;
	localparam logic [PHI_W-1:0] RST_MIN_DELTA_PHI = 12'd1792;

	// serial divider: numerator (L-S)<<16, denominator L+S
	localparam int DIV_NUM_W = 2 * PT_W;
	localparam int DIV_DEN_W = PT_W + 1;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	typedef enum logic [1:0] {
		STAT_PAIR   = 2'd0,
		STAT_FEW    = 2'd1,
		STAT_SOFT   = 2'd2,
		STAT_NOPAIR = 2'd3
	} status_t;

	typedef struct packed {
		logic [PT_W-1:0]         jet_pt;
		logic signed [ETA_W-1:0] jet_eta;
		logic [PHI_W-1:0]        jet_phi;
		logic                    last_jet;
	} jet_in_t;

	typedef struct packed {
		status_t             status;
		logic [PT_W-1:0]     leader_pt;
		logic [PT_W-1:0]     partner_pt;
		logic [PHI_W-1:0]    delta_phi;
		logic [ASYM_W-1:0]   asymmetry;
		logic                overflow;
	} result_t;

	// one stored jet
	typedef struct packed {
		logic [PT_W-1:0]  pt;
		logic [PHI_W-1:0] phi;
	} jet_entry_t;

	localparam int ENTRY_W = $bits(jet_entry_t);

	// wrapped azimuth difference, 0..2048
	function automatic logic [PHI_W-1:0] wrap_dphi(input logic [PHI_W-1:0] a,
	                                               input logic [PHI_W-1:0] b);
		logic [PHI_W-1:0] d;
		d = a - b;
		if (d > 12'd2048) begin
			d = 12'd0 - d;
		end
		return d;
	endfunction

endpackage
`default_nettype wire

>>> rtl/dijet_pair_selector_top.sv
// Dijet pair selector top level: jet filter and loader, store scan, result register.
// Depends on dps_pkg, dps_ram (jet store) and dps_div (asymmetry divider).
//
//  channel | signals                           | direction | transfer when
//  --------+-----------------------------------+-----------+----------------------------
//  input   | in_valid  in_ready  in_data       | in        | in_valid & in_ready
//  result  | out_valid out_ready out_data      | out       | out_valid & out_ready
//  config  | cfg_valid cfg_ready cfg_index/data| in        | cfg_valid & cfg_ready
//
// Sequence: a jet is taken on each input transfer. After the jet marked last_jet the
//   block passes the check state; unless too few jets are kept or the leader is too
//   soft, it then scans the store (one store read per cycle, registered RAM read), runs
//   the divider when a pair is found, and moves the result into the output register. The
//   scan over the store's single read port and the bit-serial divider dominate the sequence.
// Reset: control state and config registers return to defaults; the store is not
//   cleared, entries at or above kept_count are never read.
// Stalls: in_ready is high only while loading; a held result does not block loading
//   of the next event, only the hand-off of that event's result.
`default_nettype none
module dijet_pair_selector_top
	import dps_pkg::*;
#(
	parameter int MAX_JETS = DPS_MAX_JETS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output      logic                  in_ready,
	input  wire jet_in_t               in_data,
	output      logic                  out_valid,
	input  wire logic                  out_ready,
	output      result_t               out_data,
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ADDR_W = $clog2(MAX_JETS);
	localparam int CNT_W  = $clog2(MAX_JETS + 1);

	typedef enum logic [4:0] {
		ST_LOAD   = 5'b00001,
		ST_CHECK  = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DIV    = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [PT_W-1:0]  min_jet_pt_q;
	logic [PT_W-1:0]  min_lead_pt_q;
	logic [ETA_W-1:0] max_abs_eta_q;
	logic [PHI_W-1:0] min_delta_phi_q;

	// event state
	logic [CNT_W-1:0] kept_count_q;
	logic [PT_W-1:0]  leader_pt_q;
	logic [PHI_W-1:0] leader_phi_q;
	logic             dropped_q;

	// scan state
	logic [CNT_W-1:0] rd_cnt_q;
	logic             vld_s1;
	logic             found_q;
	logic [PT_W-1:0]  best_pt_q;
	logic [PHI_W-1:0] best_dphi_q;

	status_t           status_q;
	logic [ASYM_W-1:0] asym_q;
	logic              out_valid_q;
	result_t           out_data_q;

	// input decode
	logic             in_xfer;
	logic [ETA_W-1:0] abs_eta;
	logic             keep;
	logic             full;
	logic             store_we;

	// store access
	logic             rd_en;
	logic [ENTRY_W-1:0] rd_raw;
	jet_entry_t       rd_entry;
	jet_entry_t       wr_entry;
	logic [PHI_W-1:0] scan_dphi;
	logic             scan_hit;
	logic             scan_end;

	// divider
	logic                 div_start;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quot;
	logic [DIV_NUM_W-1:0] div_numer;
	logic [DIV_DEN_W-1:0] div_denom;

	logic out_free;

	assign in_ready  = (state_q == ST_LOAD);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;

	// absolute eta as unsigned; the most negative code maps to 2048
	assign abs_eta  = in_data.jet_eta[ETA_W-1] ? (ETA_W'(0) - in_data.jet_eta) :
	                  in_data.jet_eta;
	assign keep     = (in_data.jet_pt > min_jet_pt_q) && (abs_eta < max_abs_eta_q);
	assign full     = (kept_count_q == CNT_W'(MAX_JETS));
	assign store_we = in_xfer && keep && !full;

	assign wr_entry.pt  = in_data.jet_pt;
	assign wr_entry.phi = in_data.jet_phi;

	assign rd_en    = (state_q == ST_SCAN) && (rd_cnt_q < kept_count_q);
	assign rd_entry = jet_entry_t'(rd_raw);

	dps_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_JETS)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (kept_count_q[ADDR_W-1:0]),
		.wdata (ENTRY_W'(wr_entry)),
		.re    (rd_en),
		.raddr (rd_cnt_q[ADDR_W-1:0]),
		.rdata (rd_raw)
	);

	// compare the returning entry against the best partner so far
	assign scan_dphi = wrap_dphi(leader_phi_q, rd_entry.phi);
	assign scan_hit  = vld_s1 && (scan_dphi >= min_delta_phi_q) &&
	                   (!found_q || (rd_entry.pt > best_pt_q));
	assign scan_end  = (state_q == ST_SCAN) && !rd_en && !vld_s1;

	// leader is the maximum of kept jets, so the difference never goes negative
	assign div_start = scan_end && found_q;
	assign div_numer = {leader_pt_q - best_pt_q, {PT_W{1'b0}}};
	assign div_denom = {1'b0, leader_pt_q} + {1'b0, best_pt_q};

	dps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_numer),
		.denom  (div_denom),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign out_free = !out_valid_q || out_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_jet_pt_q    <= RST_MIN_JET_PT;
			min_lead_pt_q   <= RST_MIN_LEAD_PT;
			max_abs_eta_q   <= RST_MAX_ABS_ETA;
			min_delta_phi_q <= RST_MIN_DELTA_PHI;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MIN_JET_PT:    min_jet_pt_q    <= cfg_data;
				CFG_MIN_LEAD_PT:   min_lead_pt_q   <= cfg_data;
				CFG_MAX_ABS_ETA:   max_abs_eta_q   <= cfg_data[ETA_W-1:0];
				CFG_MIN_DELTA_PHI: min_delta_phi_q <= cfg_data[PHI_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and event state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			kept_count_q <= '0;
			leader_pt_q  <= '0;
			leader_phi_q <= '0;
			dropped_q    <= 1'b0;
			rd_cnt_q     <= '0;
			vld_s1       <= 1'b0;
			found_q      <= 1'b0;
			status_q     <= STAT_FEW;
			out_valid_q  <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			// raise the result when it moves into the output register, drop it on transfer
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (store_we) begin
							kept_count_q <= kept_count_q + CNT_W'(1);
							// earliest jet stays leader on equal momentum
							if (kept_count_q == '0 || in_data.jet_pt > leader_pt_q) begin
								leader_pt_q  <= in_data.jet_pt;
								leader_phi_q <= in_data.jet_phi;
							end
						end
						if (keep && full) begin
							dropped_q <= 1'b1;
						end
						if (in_data.last_jet) begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					rd_cnt_q <= '0;
					found_q  <= 1'b0;
					if (kept_count_q < CNT_W'(2)) begin
						status_q <= STAT_FEW;
						state_q  <= ST_FINISH;
					end else if (leader_pt_q <= min_lead_pt_q) begin
						status_q <= STAT_SOFT;
						state_q  <= ST_FINISH;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					if (scan_hit) begin
						found_q <= 1'b1;
					end
					if (scan_end) begin
						if (found_q) begin
							status_q <= STAT_PAIR;
							state_q  <= ST_DIV;
						end else begin
							status_q <= STAT_NOPAIR;
							state_q  <= ST_FINISH;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// hold until the output register is free, then clear the event
					if (out_free) begin
						kept_count_q <= '0;
						leader_pt_q  <= '0;
						leader_phi_q <= '0;
						dropped_q    <= 1'b0;
						state_q      <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// scan and result payload
	always_ff @(posedge clk) begin
		if (scan_hit) begin
			best_pt_q   <= rd_entry.pt;
			best_dphi_q <= scan_dphi;
		end
		if (div_done) begin
			asym_q <= (div_quot[DIV_NUM_W-1:ASYM_W] != '0) ? {ASYM_W{1'b1}} :
			          div_quot[ASYM_W-1:0];
		end
		if (state_q == ST_FINISH && out_free) begin
			out_data_q.status     <= status_q;
			out_data_q.leader_pt  <= (status_q == STAT_FEW) ? '0 : leader_pt_q;
			out_data_q.partner_pt <= (status_q == STAT_PAIR) ? best_pt_q : '0;
			out_data_q.delta_phi  <= (status_q == STAT_PAIR) ? best_dphi_q : '0;
			out_data_q.asymmetry  <= (status_q == STAT_PAIR) ? asym_q : '0;
			out_data_q.overflow   <= dropped_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

>>> rtl/dps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependency.
`default_nettype none
module dps_ram #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/dps_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on dps_pkg for operand widths.
`default_nettype none
module dps_div
	import dps_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [DIV_NUM_W-1:0] numer,
	input  wire logic [DIV_DEN_W-1:0] denom,
	output      logic                 done,
	output      logic [DIV_NUM_W-1:0] quot
);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] sh_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 ge;

	// the remainder stays below the divisor, so it fits the divisor's width
	assign trial = {rem_q, sh_q[DIV_NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= numer;
			den_q <= denom;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
			sh_q  <= {sh_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = sh_q;

endmodule
`default_nettype wire

>>> rtl/dps_checker.sv
// Port-level checks for the dijet pair selector, bound to the top level.
// Depends on dps_pkg and dijet_pair_selector_top.
`default_nettype none
module dps_checker
	import dps_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    in_valid,
	input wire logic    in_ready,
	input wire jet_in_t in_data,
	input wire logic    out_valid,
	input wire logic    out_ready,
	input wire result_t out_data
);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// only the last jet of an event leads to a new result
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_data.last_jet |=> !$rose(out_valid))
		else $error("result raised after a non-final jet");

	// the block stops taking jets once an event is closed
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_jet |=> !in_ready)
		else $error("jet taken right after the final jet");

	// a new result is produced only while loading is paused
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result produced while loading");

	// the partner never outranks the leader
	a_partner_le_leader: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STAT_PAIR |->
			out_data.partner_pt <= out_data.leader_pt)
		else $error("partner momentum above leader");

endmodule

bind dijet_pair_selector_top dps_checker u_dps_checker (.*);
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for dijet_pair_selector_top: a directed table of jets, then random events under
// several register settings, each result checked against its typed row or the event model kept here.
// Depends on dps_pkg and the RTL of the dijet pair selector.
module tb;
	import dps_pkg::*;

	localparam int STORE_DEPTH     = DPS_MAX_JETS;
	// allow for the end of an event with a full store, plus margin
	localparam int DRAIN_CYCLES    = STORE_DEPTH + 66;
	localparam int RANDOM_ITEMS    = 950;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int HOLD_AT_FIRST   = 30;
	localparam int HOLD_AT_SECOND  = 100;
	// no register sits behind this index, so a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd7;

	typedef enum {RX_OPEN, RX_LIGHT, RX_THIRD, RX_HEAVY} rx_mode_t;

	typedef struct {
		jet_in_t jet;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	jet_in_t               in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	result_t               out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// event model state: kept jets, leader and drop flag, plus the current cuts
	logic [PT_W-1:0]  kept_pt  [STORE_DEPTH];
	logic [PHI_W-1:0] kept_phi [STORE_DEPTH];
	int               n_kept;
	int               lead_slot;
	logic [PT_W-1:0]  lead_pt;
	bit               store_dropped;
	logic [PT_W-1:0]  cut_jet_pt;
	logic [PT_W-1:0]  cut_lead_pt;
	logic [ETA_W-1:0] cut_abs_eta;
	logic [PHI_W-1:0] cut_dphi;

	result_t  awaited_results[$];
	int       mismatches   = 0;
	int       results_seen = 0;
	int       random_sent  = 0;
	int       burst_left   = 0;
	rx_mode_t rx_mode      = RX_OPEN;
	int       mode_left    = 0;
	int       hold_left    = 0;
	int       holds_done   = 0;

	dijet_pair_selector_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop: far above the slowest correct run.
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		$display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Advance the event model by one jet. Filter and store it, track the leader, and on
	// the last jet build the result and clear the event.
	task automatic dijet_select(input jet_in_t j, output bit emits, output result_t r);
		int               abs_eta;
		int               d;
		int               best_d;
		int               i;
		bit               found;
		logic [PT_W-1:0]  best_pt;
		logic [PHI_W-1:0] lead_phi;
		longint           quot;
		r       = '0;
		emits   = 1'b0;
		abs_eta = int'(j.jet_eta);
		if (abs_eta < 0) begin
			abs_eta = -abs_eta;
		end
		if (j.jet_pt > cut_jet_pt && abs_eta < int'(cut_abs_eta)) begin
			if (n_kept < STORE_DEPTH) begin
				kept_pt[n_kept]  = j.jet_pt;
				kept_phi[n_kept] = j.jet_phi;
				// strictly greater: on a tie the earlier jet stays leader
				if (n_kept == 0 || j.jet_pt > lead_pt) begin
					lead_slot = n_kept;
					lead_pt   = j.jet_pt;
				end
				n_kept++;
			end else begin
				store_dropped = 1'b1;
			end
		end
		if (!j.last_jet) begin
			return;
		end
		emits      = 1'b1;
		r.status   = STAT_PAIR;
		r.overflow = store_dropped;
		if (n_kept < 2) begin
			r.status = STAT_FEW;
		end else begin
			r.leader_pt = lead_pt;
			lead_phi    = kept_phi[lead_slot];
			if (lead_pt <= cut_lead_pt) begin
				r.status = STAT_SOFT;
			end else begin
				found   = 1'b0;
				best_pt = '0;
				best_d  = 0;
				for (i = 0; i < n_kept; i++) begin
					d = (int'(lead_phi) - int'(kept_phi[i])) & 4095;
					if (d > 2048) begin
						d = 4096 - d;
					end
					if (d >= int'(cut_dphi) && (!found || kept_pt[i] > best_pt)) begin
						found   = 1'b1;
						best_pt = kept_pt[i];
						best_d  = d;
					end
				end
				if (!found) begin
					r.status = STAT_NOPAIR;
				end else begin
					quot = ((longint'(lead_pt) - longint'(best_pt)) * 65536) /
					       (longint'(lead_pt) + longint'(best_pt));
					r.partner_pt = best_pt;
					r.delta_phi  = best_d[PHI_W-1:0];
					r.asymmetry  = (quot > 65535) ? 16'hFFFF : quot[ASYM_W-1:0];
				end
			end
		end
		n_kept        = 0;
		lead_slot     = 0;
		lead_pt       = '0;
		store_dropped = 1'b0;
	endtask

	// Compare one result transfer with the oldest expectation, field by field.
	task automatic check_result(input result_t got);
		result_t want;
		if (awaited_results.size() == 0) begin
			report_mismatch("result with nothing awaited, status", got.status, 0);
			return;
		end
		want = awaited_results.pop_front();
		if (got.status !== want.status)
			report_mismatch("status", got.status, want.status);
		if (got.leader_pt !== want.leader_pt)
			report_mismatch("leader_pt", got.leader_pt, want.leader_pt);
		if (got.partner_pt !== want.partner_pt)
			report_mismatch("partner_pt", got.partner_pt, want.partner_pt);
		if (got.delta_phi !== want.delta_phi)
			report_mismatch("delta_phi", got.delta_phi, want.delta_phi);
		if (got.asymmetry !== want.asymmetry)
			report_mismatch("asymmetry", got.asymmetry, want.asymmetry);
		if (got.overflow !== want.overflow)
			report_mismatch("overflow", got.overflow, want.overflow);
	endtask

	// Result side: check the transfer seen at this edge, then pick out_ready for the next
	// cycle. Two long hold-offs let the block fill up and push back on the jet input.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				check_result(out_data);
				results_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (holds_done < 2 &&
			             results_seen >= (holds_done == 0 ? HOLD_AT_FIRST : HOLD_AT_SECOND)) begin
				hold_left = HOLD_OFF_CYCLES;
				holds_done++;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (rx_mode)
					RX_OPEN:  out_ready <= 1'b1;
					RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
					RX_THIRD: out_ready <= (mode_left % 3 == 0);
					default:  out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Offer one jet and hold it until the transfer. The sender runs in bursts; a burst
	// ends in an idle gap, and now and then a long burst runs without gaps.
	task automatic offer_jet(input jet_in_t j, input bit typed, input result_t want);
		bit      emits;
		result_t r;
		if (burst_left == 0) begin
			if ($urandom_range(0, 9) == 0) begin
				burst_left = $urandom_range(60, 200);
			end else begin
				burst_left = $urandom_range(1, 24);
			end
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= j;
		do @(posedge clk); while (!in_ready);
		dijet_select(j, emits, r);
		if (emits) begin
			awaited_results.insert(awaited_results.size(), typed ? want : r);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_MIN_JET_PT:    cut_jet_pt  = val;
			CFG_MIN_LEAD_PT:   cut_lead_pt = val;
			CFG_MAX_ABS_ETA:   cut_abs_eta = val[ETA_W-1:0];
			CFG_MIN_DELTA_PHI: cut_dphi    = val[PHI_W-1:0];
			default: ;
		endcase
	endtask

	// Drain the block, let the last scan run out, then load a full register setting.
	task automatic apply_setting(input logic [CFG_DATA_W-1:0] jet_pt_cut,
	                             input logic [CFG_DATA_W-1:0] lead_pt_cut,
	                             input logic [CFG_DATA_W-1:0] eta_cut,
	                             input logic [CFG_DATA_W-1:0] dphi_cut);
		in_valid  <= 1'b0;
		burst_left = 0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(CFG_MIN_JET_PT, jet_pt_cut);
		write_reg(CFG_MIN_LEAD_PT, lead_pt_cut);
		write_reg(CFG_MAX_ABS_ETA, eta_cut);
		write_reg(CFG_MIN_DELTA_PHI, dphi_cut);
		write_reg(CFG_SPARE_IDX, 16'($urandom_range(0, 65535)));
		cfg_valid <= 1'b0;
	endtask

	// Build a jet. A clean jet passes the current cuts where they allow it at all, and
	// often sits roughly opposite the event axis so that pairs show up.
	function automatic jet_in_t make_jet(input bit clean, input logic [PHI_W-1:0] axis,
	                                     input bit last);
		jet_in_t j;
		int      lo;
		int      hi;
		int      mag;
		j.jet_pt   = 16'($urandom_range(0, 65535));
		j.jet_eta  = 12'($urandom_range(0, 4095));
		j.jet_phi  = 12'($urandom_range(0, 4095));
		j.last_jet = last;
		if (clean) begin
			if (cut_jet_pt != 16'hFFFF) begin
				lo = int'(cut_jet_pt) + 1;
				hi = (lo + 700 > 65535) ? 65535 : lo + 700;
				if ($urandom_range(0, 1) == 0) begin
					hi = 65535;
				end
				j.jet_pt = 16'($urandom_range(lo, hi));
			end
			if (cut_abs_eta != '0 && cut_abs_eta <= 12'd2048) begin
				mag       = $urandom_range(0, int'(cut_abs_eta) - 1);
				j.jet_eta = 12'(($urandom_range(0, 1) == 0) ? -mag : mag);
			end
			if ($urandom_range(0, 9) < 4) begin
				j.jet_phi = 12'(int'(axis) + 1748 + int'($urandom_range(0, 600)));
			end
		end
		return j;
	endfunction

	// Offer whole events until about n_items jets went out; mostly clean jets with some
	// noise mixed in. fill_store opens with an event that runs past the store.
	task automatic run_events(input int n_items, input bit fill_store);
		int               sent;
		int               len;
		int               k;
		int               pick;
		bit               all_clean;
		logic [PHI_W-1:0] axis;
		sent = 0;
		while (sent < n_items) begin
			pick      = $urandom_range(0, 99);
			all_clean = 1'b0;
			if (fill_store) begin
				len        = STORE_DEPTH + $urandom_range(1, 8);
				all_clean  = 1'b1;
				fill_store = 1'b0;
			end else if (pick < 4) begin
				len = $urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 14);
			end else if (pick < 16) begin
				len = $urandom_range(8, 24);
			end else begin
				len = $urandom_range(1, 6);
			end
			axis = 12'($urandom_range(0, 4095));
			for (k = 0; k < len; k++) begin
				offer_jet(make_jet(all_clean || $urandom_range(0, 99) >= 12, axis, k == len - 1),
				          1'b0, '0);
			end
			sent += len;
		end
		random_sent += sent;
	endtask

	function automatic dir_row_t jet_row(input int pt, input int eta, input int phi,
	                                     input bit last, input bit typed = 1'b0,
	                                     input status_t st = STAT_PAIR, input int lead = 0,
	                                     input int part = 0, input int dphi = 0,
	                                     input int asym = 0);
		dir_row_t r;
		r.jet.jet_pt          = 16'(pt);
		r.jet.jet_eta         = 12'(eta);
		r.jet.jet_phi         = 12'(phi);
		r.jet.last_jet        = last;
		r.typed               = typed;
		r.want                = '0;
		r.want.status         = st;
		r.want.leader_pt      = 16'(lead);
		r.want.partner_pt     = 16'(part);
		r.want.delta_phi      = 12'(dphi);
		r.want.asymmetry      = 16'(asym);
		return r;
	endfunction

	initial begin
		dir_row_t directed[$];

		// Directed table, run under the reset cuts (pt > 128, |eta| < 358, dphi >= 1792).
		// empty event: a lone soft jet, nothing kept
		directed.insert(directed.size(), jet_row(0, 0, 0, 1, 1'b1, STAT_FEW));
		// hardest jet against one just above the pt cut and just inside the eta cut
		directed.insert(directed.size(), jet_row(65535, 357, 0, 0));
		directed.insert(directed.size(), jet_row(129, -357, 2048, 1));
		// eta extremes and both cut edges are dropped; one kept jet is too few
		directed.insert(directed.size(), jet_row(1000, -2048, 100, 0));
		directed.insert(directed.size(), jet_row(1000, 2047, 100, 0));
		directed.insert(directed.size(), jet_row(1000, 358, 100, 0));
		directed.insert(directed.size(), jet_row(128, 0, 100, 0));
		directed.insert(directed.size(), jet_row(500, 0, 0, 1, 1'b1, STAT_FEW));
		// leader exactly at the leading cut is too soft
		directed.insert(directed.size(), jet_row(320, 0, 0, 0));
		directed.insert(directed.size(), jet_row(200, 0, 2048, 1, 1'b1, STAT_SOFT, 320));
		// azimuth wraps to 1791, one short of the cut: no partner
		directed.insert(directed.size(), jet_row(1000, 0, 0, 0));
		directed.insert(directed.size(),
		                jet_row(900, 0, 2305, 1, 1'b1, STAT_NOPAIR, 1000));
		// equal leaders: the first stays leader, the second becomes its partner
		directed.insert(directed.size(), jet_row(800, 0, 100, 0));
		directed.insert(directed.size(), jet_row(800, 0, 2148, 0));
		directed.insert(directed.size(),
		                jet_row(600, 0, 2148, 1, 1'b1, STAT_PAIR, 800, 800, 2048, 0));
		// equal partners: the earlier one wins
		directed.insert(directed.size(), jet_row(900, -1, 0, 0));
		directed.insert(directed.size(), jet_row(500, 1, 2048, 0));
		directed.insert(directed.size(), jet_row(500, 0, 1900, 1));
		// wrapped difference exactly at the cut qualifies
		directed.insert(directed.size(), jet_row(2000, 0, 4000, 0));
		directed.insert(directed.size(), jet_row(1500, 0, 1696, 1));

		n_kept        = 0;
		lead_slot     = 0;
		lead_pt       = '0;
		store_dropped = 1'b0;
		cut_jet_pt    = RST_MIN_JET_PT;
		cut_lead_pt   = RST_MIN_LEAD_PT;
		cut_abs_eta   = RST_MAX_ABS_ETA;
		cut_dphi      = RST_MIN_DELTA_PHI;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			offer_jet(directed[i].jet, directed[i].typed, directed[i].want);
		end

		// loose cuts, first event overflows the store
		apply_setting(16'd0, 16'd0, 16'd2048, 16'd1);
		run_events(140, 1'b1);
		// zero azimuth cut: the leader may pair with itself
		apply_setting(16'd128, 16'd320, 16'd358, 16'd0);
		run_events(120, 1'b1);
		// tightest cuts: nothing passes
		apply_setting(16'hFFFF, 16'hFFFF, 16'h0FFF, 16'h0FFF);
		run_events(40, 1'b0);
		// only the hardest jets pass; eta data masks to 2048, azimuth cut at its top
		apply_setting(16'hFFFE, 16'd0, 16'hF800, 16'd2048);
		run_events(60, 1'b0);

		while (random_sent < RANDOM_ITEMS) begin
			apply_setting(16'($urandom_range(0, 1500)),
			              16'($urandom_range(0, 6000)),
			              16'(($urandom_range(0, 3) != 0) ? $urandom_range(100, 2048)
			                                              : $urandom_range(0, 65535)),
			              16'(($urandom_range(0, 3) != 0) ? $urandom_range(1, 2048)
			                                              : $urandom_range(0, 65535)));
			run_events(100, $urandom_range(0, 2) == 0);
		end

		// drop valid, wait out every awaited result, then give stray results time to show
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
